// ----- src/chct_pkg.sv -----
// shared types and codes of the canonical huffman code table
`default_nettype none

package chct_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned LEN_SEL_W = 5;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned NEXT_CODE_W = CODE_W + 1;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam action_t ACT_CLEAR = 2'd0;
  localparam action_t ACT_SET_COUNT = 2'd1;
  localparam action_t ACT_ADD = 2'd2;
  localparam action_t ACT_ENCODE = 2'd3;

  localparam status_t STATUS_OK = 2'd0;
  localparam status_t STATUS_NOT_FOUND = 2'd1;
  localparam status_t STATUS_NO_ROOM = 2'd2;

  // one symbol table entry
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } sym_entry_t;

endpackage

`default_nettype wire

// ----- src/chct_req_if.sv -----
// request and response channel interfaces of the canonical huffman code table
`default_nettype none

interface chct_req_if;
  import chct_pkg::*;

  logic                 valid;
  logic                 ready;
  action_t              action;
  logic [LEN_SEL_W-1:0] length_select;
  logic [VALUE_W-1:0]   value;

  modport source (output valid, action, length_select, value, input ready);
  modport sink (input valid, action, length_select, value, output ready);
endinterface

interface chct_rsp_if;
  import chct_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [CODE_W-1:0] code_word;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, status, code_word, code_length, input ready);
  modport sink (input valid, status, code_word, code_length, output ready);
endinterface

`default_nettype wire

// ----- src/canonical_huffman_code_table.sv -----
// canonical huffman encode table: count loading, code assignment and symbol lookup
//
// requests come in on req_i (action, length_select, value); exactly one response per
// request leaves on rsp_o (status, code_word, code_length), both valid/ready channels.
// clear and set-count requests, and encode of an unknown symbol, load the output
// register directly; encode of a known symbol first does a synchronous read of the
// symbol memory (FSM_READ); add first steps over the empty code lengths, one length
// per cycle, in FSM_SEEK. one request is in flight at a time.
// the response sits in an output register; a new request is taken in the cycle the
// previous response is taken, so a stalled receiver holds the block in idle with
// ready low until the response leaves.
// reset (asynchronous, active low) clears the length counts, the per-symbol valid
// flags and the assignment state at once; the code memory itself is never cleared,
// entries are only read when their valid flag is set. a clear request does the same.
`default_nettype none

module canonical_huffman_code_table #(
  parameter int unsigned MAX_CODE_LENGTH = 16,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  chct_req_if.sink    req_i,
  chct_rsp_if.source  rsp_o
);
  import chct_pkg::*;

  localparam int unsigned IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned LIDX_W = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
  localparam logic [VALUE_W:0] SYM_LIMIT = (VALUE_W + 1)'(SYMBOL_COUNT);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_LENGTH);

  // sequencer states
  localparam logic [1:0] FSM_IDLE = 2'd0;
  localparam logic [1:0] FSM_SEEK = 2'd1;
  localparam logic [1:0] FSM_READ = 2'd2;

  logic [1:0] state_q, state_d;

  // per-length code counts, small enough for flops
  logic [VALUE_W-1:0] counts_q [MAX_CODE_LENGTH];
  logic [VALUE_W-1:0] counts_d [MAX_CODE_LENGTH];

  // one valid flag per symbol, cleared at once by reset or clear
  logic [SYMBOL_COUNT-1:0] valid_q, valid_d;

  // running canonical assignment
  logic                   started_q, started_d;
  logic [LEN_W-1:0]       cur_len_q, cur_len_d;
  logic [NEXT_CODE_W-1:0] next_code_q, next_code_d;
  logic [VALUE_W-1:0]     left_q, left_d;

  // symbol of the add in progress
  logic [VALUE_W-1:0] sym_q, sym_d;

  // output register
  logic              out_valid_q, out_valid_d;
  status_t           out_status_q, out_status_d;
  logic [CODE_W-1:0] out_code_q, out_code_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;

  // symbol code memory, synchronous read
  sym_entry_t mem [SYMBOL_COUNT];
  sym_entry_t rd_data_q;
  logic       mem_we;
  logic       rd_en;
  sym_entry_t wr_data;

  logic             accept;
  logic             req_sym_ok;
  logic             held_sym_ok;
  logic [IDX_W-1:0] req_idx;
  logic [IDX_W-1:0] held_idx;
  logic [LEN_W-1:0] sel_m1;
  logic             code_fits;

  assign req_i.ready = (state_q == FSM_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.code_word   = out_code_q;
  assign rsp_o.code_length = out_len_q;

  assign req_sym_ok  = {1'b0, req_i.value} < SYM_LIMIT;
  assign held_sym_ok = {1'b0, sym_q} < SYM_LIMIT;
  assign req_idx     = req_i.value[IDX_W-1:0];
  assign held_idx    = sym_q[IDX_W-1:0];
  assign sel_m1      = req_i.length_select - LEN_W'(1);
  // the next code must fit in the current length, else the counts are oversubscribed
  assign code_fits   = (next_code_q >> cur_len_q) == '0;

  assign wr_data.code = next_code_q[CODE_W-1:0];
  assign wr_data.len  = cur_len_q;

  always_comb begin
    state_d      = state_q;
    counts_d     = counts_q;
    valid_d      = valid_q;
    started_d    = started_q;
    cur_len_d    = cur_len_q;
    next_code_d  = next_code_q;
    left_d       = left_q;
    sym_d        = sym_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_code_d   = out_code_q;
    out_len_d    = out_len_q;
    mem_we       = 1'b0;
    rd_en        = 1'b0;

    // response taken downstream
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          case (req_i.action)
            ACT_CLEAR: begin
              for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                counts_d[i] = '0;
              end
              valid_d      = '0;
              started_d    = 1'b0;
              cur_len_d    = LEN_W'(1);
              next_code_d  = '0;
              left_d       = '0;
              out_valid_d  = 1'b1;
              out_status_d = STATUS_OK;
              out_code_d   = '0;
              out_len_d    = '0;
            end
            ACT_SET_COUNT: begin
              // lengths of zero or beyond the maximum are ignored
              if (req_i.length_select != '0 && req_i.length_select <= MAX_LEN) begin
                counts_d[sel_m1[LIDX_W-1:0]] = req_i.value;
              end
              out_valid_d  = 1'b1;
              out_status_d = STATUS_OK;
              out_code_d   = '0;
              out_len_d    = '0;
            end
            ACT_ADD: begin
              sym_d = req_i.value;
              // first add starts the assignment at length one, code zero
              if (!started_q) begin
                started_d   = 1'b1;
                cur_len_d   = LEN_W'(1);
                next_code_d = '0;
                left_d      = counts_q[0];
              end
              state_d = FSM_SEEK;
            end
            ACT_ENCODE: begin
              if (req_sym_ok && valid_q[req_idx]) begin
                rd_en   = 1'b1;
                state_d = FSM_READ;
              end else begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_NOT_FOUND;
                out_code_d   = '0;
                out_len_d    = '0;
              end
            end
            default: begin
              state_d = FSM_IDLE;
            end
          endcase
        end
      end

      FSM_SEEK: begin
        if (left_q == '0 && cur_len_q < MAX_LEN) begin
          // step to the next length, one per cycle
          next_code_d = {next_code_q[NEXT_CODE_W-2:0], 1'b0};
          cur_len_d   = cur_len_q + LEN_W'(1);
          left_d      = counts_q[cur_len_q[LIDX_W-1:0]];
        end else begin
          state_d     = FSM_IDLE;
          out_valid_d = 1'b1;
          if (!held_sym_ok || left_q == '0 || !code_fits) begin
            out_status_d = STATUS_NO_ROOM;
            out_code_d   = '0;
            out_len_d    = '0;
          end else begin
            out_status_d = STATUS_OK;
            out_code_d   = next_code_q[CODE_W-1:0];
            out_len_d    = cur_len_q;
            next_code_d  = next_code_q + NEXT_CODE_W'(1);
            left_d       = left_q - VALUE_W'(1);
            // a duplicate keeps its first code
            if (!valid_q[held_idx]) begin
              valid_d[held_idx] = 1'b1;
              mem_we            = 1'b1;
            end
          end
        end
      end

      FSM_READ: begin
        state_d      = FSM_IDLE;
        out_valid_d  = 1'b1;
        out_status_d = STATUS_OK;
        out_code_d   = rd_data_q.code;
        out_len_d    = rd_data_q.len;
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
        counts_q[i] <= '0;
      end
      valid_q     <= '0;
      started_q   <= 1'b0;
      cur_len_q   <= LEN_W'(1);
      next_code_q <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      counts_q    <= counts_d;
      valid_q     <= valid_d;
      started_q   <= started_d;
      cur_len_q   <= cur_len_d;
      next_code_q <= next_code_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    out_status_q <= out_status_d;
    out_code_q   <= out_code_d;
    out_len_q    <= out_len_d;
  end

  // symbol memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[held_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[req_idx];
    end
  end

endmodule

`default_nettype wire
